@@ rtl/core/dltq_pkg.sv @@
// package for the delta list timer queue: sizes, codes and shared types
package dltq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DELAY_BITS = 16;
  localparam int ID_BITS    = 4;
  localparam int NUM_IDS    = 16;
  localparam int POS_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  typedef logic [DELAY_BITS-1:0] delta_t;
  typedef logic [ID_BITS-1:0]    tid_t;

  localparam logic [DELAY_BITS-1:0] DMAX = {DELAY_BITS{1'b1}};

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_DEC_HEAD,
    OP_INSERT,
    OP_REMOVE,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_BITS-1:0] pos;
    tid_t               id;
    delta_t             d;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARM_WALK,
    S_CAN_WALK,
    S_TICK_DEC,
    S_TICK_RING,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/dltq_cell.sv @@
// one cell of the delta list: holds an entry and shifts with its neighbors
module dltq_cell (
  input  logic               clk,
  input  dltq_pkg::cell_cmd_t cmd,
  input  logic [dltq_pkg::POS_BITS-1:0] my_pos,
  input  dltq_pkg::tid_t     prev_id,
  input  dltq_pkg::delta_t   prev_d,
  input  dltq_pkg::tid_t     next_id,
  input  dltq_pkg::delta_t   next_d,
  output dltq_pkg::tid_t     id_o,
  output dltq_pkg::delta_t   d_o
);
  import dltq_pkg::*;

  tid_t   id_r, id_nxt;
  delta_t d_r, d_nxt;
  logic [DELAY_BITS:0] sum;

  assign sum = {1'b0, next_d} + {1'b0, d_r};

  // next entry value for the broadcast operation
  always_comb begin
    id_nxt = id_r;
    d_nxt  = d_r;
    case (cmd.op)
      OP_DEC_HEAD: begin
        if (my_pos == '0 && d_r != '0) d_nxt = d_r - 1'b1;
      end
      OP_INSERT: begin
        if (my_pos == cmd.pos) begin
          id_nxt = cmd.id;
          d_nxt  = cmd.d;
        end else if (my_pos > cmd.pos) begin
          id_nxt = prev_id;
          // the old entry at the insert point now follows the new one
          if (my_pos == cmd.pos + 1'b1) d_nxt = prev_d - cmd.d;
          else d_nxt = prev_d;
        end
      end
      OP_REMOVE: begin
        if (my_pos == cmd.pos) begin
          id_nxt = next_id;
          d_nxt  = sum[DELAY_BITS] ? DMAX : sum[DELAY_BITS-1:0];
        end else if (my_pos > cmd.pos) begin
          id_nxt = next_id;
          d_nxt  = next_d;
        end
      end
      OP_POP: begin
        id_nxt = next_id;
        d_nxt  = next_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    d_r  <= d_nxt;
  end

  assign id_o = id_r;
  assign d_o  = d_r;
endmodule

@@ rtl/core/dltq_chain.sv @@
// row of cells with neighbor links
module dltq_chain (
  input  logic               clk,
  input  dltq_pkg::cell_cmd_t cmd,
  output dltq_pkg::tid_t     ids   [dltq_pkg::CAPACITY],
  output dltq_pkg::delta_t   deltas[dltq_pkg::CAPACITY]
);
  import dltq_pkg::*;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tid_t   pid, nid;
    delta_t pd, nd;
    if (i == 0) begin : g_first
      assign pid = '0;
      assign pd  = '0;
    end else begin : g_mid
      assign pid = ids[i-1];
      assign pd  = deltas[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nid = '0;
      assign nd  = '0;
    end else begin : g_body
      assign nid = ids[i+1];
      assign nd  = deltas[i+1];
    end
    dltq_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .my_pos  (POS_BITS'(i)),
      .prev_id (pid),
      .prev_d  (pd),
      .next_id (nid),
      .next_d  (nd),
      .id_o    (ids[i]),
      .d_o     (deltas[i])
    );
  end
endmodule

@@ rtl/core/delta_list_timer_queue.sv @@
// top level: sequencer that walks the cell row one entry per cycle
// arm/cancel walk past entries, then strobe one result; a duplicate or full arm or an
// absent cancel strobes its status without a walk. a tick decrements the head, then
// strobes one result per cycle for each rung timer, or a single report if none rang.
// one item at a time; busy stays high through the last result strobe, and the next
// item can be taken the cycle after. synchronous active-low reset empties the queue.
module delta_list_timer_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [3:0]                   in_timer_id,
  input  logic [15:0]                  in_delay,
  output logic                         out_valid,
  output logic                         out_rang,
  output logic [3:0]                   out_rung_id,
  output logic [1:0]                   out_status,
  output logic                         out_last
);
  import dltq_pkg::*;

  state_t  state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] ptr_r, ptr_nxt;
  logic [NUM_IDS-1:0]  flags_r, flags_nxt;
  tid_t    id_r;
  delta_t  rem_r, rem_nxt;
  status_t st_r, st_nxt;
  logic    rang_nxt, valid_nxt;
  logic    valid_r, rang_r, last_r, last_nxt;
  tid_t    rid_r, rid_nxt;
  status_t ost_r, ost_nxt;
  cell_cmd_t cmd;
  tid_t    ids   [CAPACITY];
  delta_t  deltas[CAPACITY];
  logic [POS_BITS-1:0] pidx;
  logic    in_list;
  logic    take;

  assign pidx    = ptr_r[POS_BITS-1:0];
  assign in_list = ptr_r < cnt_r;
  assign take    = start && !busy;

  dltq_chain u_chain (.clk(clk), .cmd(cmd), .ids(ids), .deltas(deltas));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (kind_t'(in_kind))
            KIND_ARM: state_nxt =
              (flags_r[in_timer_id] || cnt_r == CNT_BITS'(CAPACITY)) ? S_DONE : S_ARM_WALK;
            KIND_CANCEL: state_nxt = flags_r[in_timer_id] ? S_CAN_WALK : S_DONE;
            KIND_TICK:   state_nxt = S_TICK_DEC;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_ARM_WALK:  if (!(in_list && deltas[pidx] <= rem_r)) state_nxt = S_DONE;
      S_CAN_WALK:  if (!in_list || ids[pidx] == id_r) state_nxt = S_DONE;
      S_TICK_DEC:  state_nxt = S_TICK_RING;
      S_TICK_RING: if (cnt_r == '0 || deltas[0] != '0) state_nxt = S_IDLE;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    flags_nxt = flags_r;
    rem_nxt   = rem_r;
    st_nxt    = st_r;
    cmd       = '{op: OP_HOLD, pos: pidx, id: id_r, d: rem_r};
    valid_nxt = 1'b0;
    rang_nxt  = 1'b0;
    rid_nxt   = '0;
    ost_nxt   = ST_OK;
    last_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        ptr_nxt = '0;
        rem_nxt = in_delay;
        st_nxt  = ST_OK;
        if (take) begin
          case (kind_t'(in_kind))
            KIND_ARM: begin
              if (flags_r[in_timer_id]) st_nxt = ST_PRESENT;
              else if (cnt_r == CNT_BITS'(CAPACITY)) st_nxt = ST_FULL;
            end
            KIND_CANCEL: if (!flags_r[in_timer_id]) st_nxt = ST_ABSENT;
            default: ;
          endcase
        end
      end
      S_ARM_WALK: begin
        if (in_list && deltas[pidx] <= rem_r) begin
          rem_nxt = rem_r - deltas[pidx];
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          cmd.op = OP_INSERT;
          cnt_nxt = cnt_r + 1'b1;
          flags_nxt[id_r] = 1'b1;
        end
      end
      S_CAN_WALK: begin
        if (!in_list) begin
          flags_nxt[id_r] = 1'b0;
          st_nxt = ST_ABSENT;
        end else if (ids[pidx] == id_r) begin
          cmd.op = OP_REMOVE;
          cnt_nxt = cnt_r - 1'b1;
          flags_nxt[id_r] = 1'b0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_TICK_DEC: begin
        cmd.op = OP_DEC_HEAD;
        st_nxt = ST_ABSENT;
      end
      S_TICK_RING: begin
        valid_nxt = 1'b1;
        if (cnt_r != '0 && deltas[0] == '0) begin
          cmd.op   = OP_POP;
          cnt_nxt  = cnt_r - 1'b1;
          flags_nxt[ids[0]] = 1'b0;
          rang_nxt = 1'b1;
          rid_nxt  = ids[0];
          st_nxt   = ST_OK;
          last_nxt = (cnt_r == CNT_BITS'(1)) || deltas[1] != '0;
        end else begin
          // nothing (more) rang: only a report when no timer rang at all
          valid_nxt = (st_r == ST_ABSENT);
          last_nxt  = 1'b1;
        end
      end
      S_DONE: begin
        valid_nxt = 1'b1;
        ost_nxt   = st_r;
        last_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      flags_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      flags_r <= flags_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    rem_r  <= rem_nxt;
    st_r   <= st_nxt;
    rang_r <= rang_nxt;
    rid_r  <= rid_nxt;
    ost_r  <= ost_nxt;
    last_r <= last_nxt;
    if (state_r == S_IDLE) id_r <= in_timer_id;
  end

  assign busy        = (state_r != S_IDLE) || valid_r;
  assign out_valid   = valid_r;
  assign out_rang    = rang_r;
  assign out_rung_id = rid_r;
  assign out_status  = ost_r;
  assign out_last    = last_r;

  // fill count never exceeds the queue size
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(CAPACITY)) else $error("entry count overflow");
  // queued flags match the fill count when idle
  a_flags_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(flags_r) == 32'(cnt_r)))
    else $error("queued flags disagree with count");
  // a rung result always reports ok status
  a_rang_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && rang_r) |-> (ost_r == ST_OK)) else $error("rang with error status");
endmodule
